@@ hdl/vrt_pkg.sv @@
package vrt_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHECK  = 2'd2,
		OP_ALLOC  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OVERLAP     = 3'd1,
		ST_NOT_FOUND   = 3'd2,
		ST_NO_SPACE    = 3'd3,
		ST_FULL        = 3'd4,
		ST_UNSUPPORTED = 3'd5
	} status_t;

	localparam logic [7:0] CHECK_FLAG_MASK = 8'h0f;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] base;
		logic [63:0] length;
		logic [7:0]  flags;
		logic [63:0] lower_bound;
		logic [63:0] upper_bound;
		logic        back_now;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] result_base;
		logic [63:0] result_length;
	} rsp_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		logic [7:0]  flags;
	} entry_t;

endpackage

@@ hdl/vrt_req_if.sv @@
interface vrt_req_if;
	logic          valid;
	logic          ready;
	vrt_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/vrt_rsp_if.sv @@
interface vrt_rsp_if;
	logic          valid;
	logic          ready;
	vrt_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/virtual_range_table.sv @@
// operation: a scan of n entries reads them in turn; insert/remove add a shift
// pass of up to n entries; allocate scans twice before its insert, so the worst
// case is an allocate
// requests: one item at a time, a new request is taken only in idle
// reset: arst_n clears entry count and control; memory contents stay undefined
// until written, only entries below the count are ever used
module virtual_range_table #(
	parameter int MAX_RANGES = 16,
	parameter int PAGE_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	vrt_req_if.sink   req,
	vrt_rsp_if.source rsp
);
	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int PW = $clog2(PAGE_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_RD, S_EVAL, S_DECIDE, S_SHRD, S_SHWR, S_INS, S_OUT
	} state_t;

	state_t state_q;
	vrt_pkg::req_t r_q;
	vrt_pkg::entry_t mem [MAX_RANGES];
	vrt_pkg::entry_t rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;      // scan index
	logic [CW-1:0] pos_q;      // insert position / removal match
	logic          pos_set_q;
	logic          found_q;    // overlap / match / containment hit
	logic          stop_q;     // first-fit gap found, removal match or check decided
	logic          flag_ok_q;
	logic [63:0]   nb_q, nl_q, cand_q;
	logic          bad_q;      // arithmetic overflow at prep
	logic [2:0]    st_q;
	logic          rsp_valid_q;
	vrt_pkg::rsp_t rsp_q;

	// memory port
	logic          we;
	logic [IW-1:0] wa, ra;
	vrt_pkg::entry_t wd;

	// prep arithmetic (one wide add plus page rounding)
	logic [64:0] end_add, end_chk, len_rnd;
	logic [64:0] top_rnd;
	always_comb begin
		end_add = {1'b0, r_q.base} + {1'b0, r_q.length};
		end_chk = end_add;
		len_rnd = ({1'b0, r_q.length} + 65'(PAGE_BYTES - 1)) >> PW << PW;
		top_rnd = (end_add + 65'(PAGE_BYTES - 1)) >> PW << PW;
	end

	// eval arithmetic
	logic [64:0] ee;
	logic [63:0] op_end;
	always_comb begin
		ee = {1'b0, rd_q.base} + {1'b0, rd_q.length};
		op_end = nb_q + nl_q;
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_comb begin
		we = 1'b0;
		wa = idx_q[IW-1:0];
		wd = rd_q;
		ra = idx_q[IW-1:0];
		case (state_q)
			S_SHRD: begin
				// insert shifts up, so fetch the entry just below
				if (r_q.operation != vrt_pkg::OP_REMOVE) begin
					ra = IW'(idx_q - 1'b1);
				end
			end
			S_SHWR: begin
				we = 1'b1;
				wa = (r_q.operation == vrt_pkg::OP_REMOVE) ? IW'(idx_q - 1'b1)
					: IW'(idx_q + 1'b1);
			end
			S_INS: begin
				we = 1'b1;
				wa = pos_q[IW-1:0];
				wd.base = nb_q;
				wd.length = nl_q;
				wd.flags = r_q.flags;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						r_q <= req.data;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					idx_q <= '0;
					pos_q <= count_q;
					pos_set_q <= 1'b0;
					found_q <= 1'b0;
					stop_q <= 1'b0;
					flag_ok_q <= 1'b0;
					cand_q <= r_q.lower_bound;
					case (r_q.operation)
						vrt_pkg::OP_ADD: begin
							nb_q <= {r_q.base[63:PW], PW'(0)};
							nl_q <= top_rnd[63:0] - {r_q.base[63:PW], PW'(0)};
							bad_q <= end_add[64] | top_rnd[64];
						end
						vrt_pkg::OP_ALLOC: begin
							nl_q <= len_rnd[63:0];
							bad_q <= len_rnd[64];
						end
						default: begin
							nb_q <= r_q.base;
							nl_q <= r_q.length;
							bad_q <= end_chk[64];
						end
					endcase
					state_q <= S_RD;
				end
				S_RD: begin
					if (idx_q >= count_q || stop_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					case (r_q.operation)
						vrt_pkg::OP_ADD: begin
							if (!(rd_q.base >= op_end) && !(ee[63:0] <= nb_q && !ee[64])) begin
								found_q <= 1'b1;
							end
							if (!pos_set_q && !(rd_q.base < nb_q)) begin
								pos_q <= idx_q;
								pos_set_q <= 1'b1;
							end
						end
						vrt_pkg::OP_REMOVE: begin
							if (rd_q.base == r_q.base && rd_q.length == r_q.length) begin
								found_q <= 1'b1;
								stop_q <= 1'b1;
								pos_q <= idx_q;
							end
						end
						vrt_pkg::OP_CHECK: begin
							if (r_q.base >= rd_q.base && ({1'b0, op_end} <= ee)) begin
								stop_q <= 1'b1;
								found_q <= 1'b1;
								flag_ok_q <= ((r_q.flags & vrt_pkg::CHECK_FLAG_MASK & ~rd_q.flags)
									== 8'h00);
							end
						end
						default: begin
							if (!({1'b0, cand_q} >= ee)) begin
								if (rd_q.base >= cand_q && rd_q.base - cand_q >= nl_q) begin
									stop_q <= 1'b1;
								end else begin
									cand_q <= ee[63:0];
								end
							end
						end
					endcase
					idx_q <= idx_q + 1'b1;
					state_q <= S_RD;
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					st_q <= vrt_pkg::ST_OK;
					case (r_q.operation)
						vrt_pkg::OP_ADD: begin
							if (!r_q.back_now) st_q <= vrt_pkg::ST_UNSUPPORTED;
							else if (bad_q) st_q <= vrt_pkg::ST_NO_SPACE;
							else if (found_q) st_q <= vrt_pkg::ST_OVERLAP;
							else if (count_q >= CW'(MAX_RANGES)) st_q <= vrt_pkg::ST_FULL;
							else begin
								idx_q <= count_q;
								state_q <= S_SHRD;
							end
						end
						vrt_pkg::OP_REMOVE: begin
							if (!found_q) st_q <= vrt_pkg::ST_NOT_FOUND;
							else begin
								idx_q <= pos_q + 1'b1;
								state_q <= S_SHRD;
							end
						end
						vrt_pkg::OP_CHECK: begin
							if (bad_q || !found_q || !flag_ok_q) st_q <= vrt_pkg::ST_NOT_FOUND;
						end
						default: begin
							if (bad_q) st_q <= vrt_pkg::ST_NO_SPACE;
							else if (count_q >= CW'(MAX_RANGES)) st_q <= vrt_pkg::ST_FULL;
							else if ({1'b0, cand_q} + {1'b0, nl_q} >= {1'b0, r_q.upper_bound})
								st_q <= vrt_pkg::ST_NO_SPACE;
							else begin
								nb_q <= cand_q;
								// insert before the first base not below cand
								idx_q <= '0;
								pos_q <= count_q;
								pos_set_q <= 1'b0;
								r_q.operation <= vrt_pkg::OP_ADD;
								r_q.back_now <= 1'b1;
								bad_q <= 1'b0;
								found_q <= 1'b0;
								stop_q <= 1'b0;
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_SHRD: begin
					// add walks down from count to pos, remove walks up
					if (r_q.operation == vrt_pkg::OP_REMOVE) begin
						if (idx_q >= count_q) begin
							count_q <= count_q - 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SHWR;
						end
					end else begin
						if (idx_q <= pos_q) begin
							state_q <= S_INS;
						end else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_SHWR;
						end
					end
				end
				S_SHWR: begin
					if (r_q.operation == vrt_pkg::OP_REMOVE) begin
						idx_q <= idx_q + 1'b1;
					end
					state_q <= S_SHRD;
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q.status <= st_q;
						rsp_q.result_base <= (st_q == vrt_pkg::ST_OK
							&& r_q.operation == vrt_pkg::OP_ADD) ? nb_q : 64'd0;
						rsp_q.result_length <= (st_q == vrt_pkg::ST_OK
							&& r_q.operation == vrt_pkg::OP_ADD) ? nl_q : 64'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
